/* hdl/nsd_pkg.sv */
// ============================================================================
// nsd_pkg
// Shared types, character codes and helpers for the NMEA sentence deframer.
// ============================================================================
package nsd_pkg;

    localparam int MAX_FIELDS_DEFAULT = 32;

    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_STAR   = 8'h2A;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_NUL    = 8'h00;

    localparam logic [15:0] TALKER_DEFAULT  = 16'h5858;
    localparam logic [23:0] MESSAGE_DEFAULT = 24'h595959;

    localparam logic [2:0] ID_LEN     = 3'd5;
    localparam logic [2:0] TALKER_LEN = 3'd2;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_BODY  = 5'b00010,
        PH_HEX1  = 5'b00100,
        PH_HEX2  = 5'b01000,
        PH_AFTER = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OUTSIDE   = 2'd1,
        ST_BAD_DIGIT = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  running_xor;
        logic [7:0]  received_sum;
        logic [5:0]  current_field;
        logic [2:0]  first_len;
        logic [15:0] talker;
        logic [23:0] message;
        logic        flag_present;
        logic        flag_bad;
        logic        flag_over;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic [5:0]  field_index;
        logic        is_content;
        logic        field_end;
        logic        sentence_end;
        logic        checksum_present;
        logic        checksum_ok;
        logic [5:0]  field_count;
        logic [15:0] talker_code;
        logic [23:0] message_code;
        status_t     status;
    } result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:         PH_IDLE,
        running_xor:   8'd0,
        received_sum:  8'd0,
        current_field: 6'd0,
        first_len:     3'd0,
        talker:        16'd0,
        message:       24'd0,
        flag_present:  1'b0,
        flag_bad:      1'b0,
        flag_over:     1'b0
    };

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

/* hdl/nsd_step.sv */
// ============================================================================
// nsd_step
// Per-byte parse step: next parser state and the result beat for one byte.
// ============================================================================
module nsd_step
    import nsd_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEFAULT
) (
    input  parse_state_t cur,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output parse_state_t nxt,
    output result_t      res
);

    localparam logic [6:0] MAX_F = 7'(MAX_FIELDS);

    logic       term;
    logic       ends;
    logic       idle_out;
    logic [4:0] hex;

    assign term = (data_byte == CHR_CR) || (data_byte == CHR_LF) || (data_byte == CHR_NUL);
    assign ends = term || last_byte;
    assign hex  = hex_decode(data_byte);

    always_comb begin
        nxt          = cur;
        res          = '0;
        res.char_out = data_byte;
        res.status   = ST_OK;
        idle_out     = 1'b0;

        case (cur.phase)
            PH_IDLE: begin
                if (data_byte == CHR_DOLLAR) begin
                    nxt       = STATE_RESET;
                    nxt.phase = PH_BODY;
                end else begin
                    idle_out = 1'b1;
                end
            end
            PH_BODY: begin
                res.field_index = cur.current_field;
                if (term) begin
                    res.field_end = 1'b1;
                end else if (data_byte == CHR_STAR) begin
                    res.field_end = 1'b1;
                    nxt.phase     = PH_HEX1;
                end else begin
                    nxt.running_xor = cur.running_xor ^ data_byte;
                    if (data_byte == CHR_COMMA) begin
                        if (({1'b0, cur.current_field} + 7'd1) < MAX_F) begin
                            nxt.current_field = cur.current_field + 6'd1;
                            res.field_end     = 1'b1;
                        end else begin
                            nxt.flag_over = 1'b1;
                            res.status    = ST_OVERFLOW;
                        end
                    end else begin
                        res.is_content = 1'b1;
                        if (cur.current_field == 6'd0 && cur.first_len < ID_LEN) begin
                            if (cur.first_len < TALKER_LEN) begin
                                nxt.talker = {cur.talker[7:0], data_byte};
                            end else begin
                                nxt.message = {cur.message[15:0], data_byte};
                            end
                            nxt.first_len = cur.first_len + 3'd1;
                        end
                    end
                end
            end
            PH_HEX1, PH_HEX2: begin
                res.field_index = cur.current_field;
                if (!term) begin
                    if (!hex[4]) begin
                        nxt.flag_bad = 1'b1;
                        res.status   = ST_BAD_DIGIT;
                        nxt.phase    = PH_AFTER;
                    end else if (cur.phase == PH_HEX1) begin
                        nxt.received_sum = {hex[3:0], 4'd0};
                        nxt.phase        = PH_HEX2;
                    end else begin
                        nxt.received_sum = {cur.received_sum[7:4], hex[3:0]};
                        nxt.flag_present = 1'b1;
                        nxt.phase        = PH_AFTER;
                    end
                end
            end
            default: begin
                res.field_index = cur.current_field;
            end
        endcase

        if (idle_out) begin
            res.status       = term ? ST_OK : ST_OUTSIDE;
            res.sentence_end = last_byte;
            res.talker_code  = last_byte ? TALKER_DEFAULT : 16'd0;
            res.message_code = last_byte ? MESSAGE_DEFAULT : 24'd0;
        end else if (ends) begin
            if (nxt.phase == PH_BODY) begin
                res.field_end = 1'b1;
            end
            res.sentence_end     = 1'b1;
            res.checksum_present = nxt.flag_present;
            res.checksum_ok      = nxt.flag_present && (nxt.received_sum == nxt.running_xor);
            res.field_count      = nxt.current_field + 6'd1;
            res.talker_code      = (nxt.first_len >= ID_LEN) ? nxt.talker : TALKER_DEFAULT;
            res.message_code     = (nxt.first_len >= ID_LEN) ? nxt.message : MESSAGE_DEFAULT;
            if (nxt.flag_over) begin
                res.status = ST_OVERFLOW;
            end else if (nxt.flag_bad) begin
                res.status = ST_BAD_DIGIT;
            end
            nxt.phase = PH_IDLE;
        end
    end

endmodule

/* hdl/nmea_sentence_deframer_top.sv */
// ============================================================================
// nmea_sentence_deframer_top
// Byte-wise NMEA 0183 sentence deframer with XOR checksum check.
// ============================================================================
// Input channel s_*: one sentence byte per beat, s_last_byte marks the end of
// the caller's buffer. Output channel m_*: exactly one result beat per input
// beat, in order, carrying the byte back with its field index and flags; the
// summary (field count, checksum, talker and message codes, final status) is
// filled in on the beat with m_sentence_end set; all but the status is zero
// elsewhere. Each byte passes through the input register, then the parse
// step into the result register. Throughput is one byte per cycle while
// m_ready stays high; the parser state is updated as a byte moves into the
// result register, so consecutive bytes flow with no gap.
// When m_ready is low the result register holds, the input register fills,
// and s_ready drops; nothing is lost or repeated, and flow resumes at full
// rate once the receiver takes the pending beat.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to waiting for a '$'.
// ============================================================================
module nmea_sentence_deframer_top
    import nsd_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_out,
    output logic [5:0]  m_field_index,
    output logic        m_is_content,
    output logic        m_field_end,
    output logic        m_sentence_end,
    output logic        m_checksum_present,
    output logic        m_checksum_ok,
    output logic [5:0]  m_field_count,
    output logic [15:0] m_talker_code,
    output logic [23:0] m_message_code,
    output logic [1:0]  m_status
);

    logic         in_valid_reg;
    logic [7:0]   in_data_reg;
    logic         in_last_reg;
    logic         m_valid_reg;
    result_t      result_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      result_next;
    logic         advance;

    nsd_step #(
        .MAX_FIELDS(MAX_FIELDS)
    ) u_step (
        .cur      (state_reg),
        .data_byte(in_data_reg),
        .last_byte(in_last_reg),
        .nxt      (state_next),
        .res      (result_next)
    );

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= STATE_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                state_reg   <= state_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_char_out         = result_reg.char_out;
    assign m_field_index      = result_reg.field_index;
    assign m_is_content       = result_reg.is_content;
    assign m_field_end        = result_reg.field_end;
    assign m_sentence_end     = result_reg.sentence_end;
    assign m_checksum_present = result_reg.checksum_present;
    assign m_checksum_ok      = result_reg.checksum_ok;
    assign m_field_count      = result_reg.field_count;
    assign m_talker_code      = result_reg.talker_code;
    assign m_message_code     = result_reg.message_code;
    assign m_status           = result_reg.status;

    // stall only when both registers are occupied
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg))
        else $error("s_ready low with a free register");

    a_ok_needs_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_checksum_ok) |-> (m_checksum_present && m_sentence_end))
        else $error("checksum_ok without a checksum at sentence end");

    a_summary_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_sentence_end) |-> (m_field_count == 6'd0 && !m_checksum_present))
        else $error("summary fields set off a sentence end");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_field_count} <= 7'(MAX_FIELDS)))
        else $error("field count beyond MAX_FIELDS");

endmodule

/* tb/sv/nmea_sentence_deframer_top_tb.sv */
// ============================================================================
// nmea_sentence_deframer_top_tb
// Self-checking regression for the byte-wise NMEA sentence deframer.
// A short table of hand-picked bytes is walked first. Some rows carry a
// hand-written result, and the rest are scored by an in-bench model of the
// parser. Random sentences follow: mostly well formed, with random fields,
// checksums, overflows, bad digits and terminators, plus stray bytes.
// The sender runs in bursts and the receiver stalls. One long receiver
// hold-off and one full drain are included. Every result beat is compared
// field by field, in order.
// ============================================================================
module nmea_sentence_deframer_top_tb
    import nsd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FIELDS   = MAX_FIELDS_DEFAULT;
    localparam int DIR_ROWS     = 27;
    localparam int RANDOM_ITEMS = 1950;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = DIR_ROWS + 400;
    localparam int DRAIN_AT     = DIR_ROWS + 1000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pinned;
        result_t    want;
    } beat_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_char_out;
    logic [5:0]  m_field_index;
    logic        m_is_content;
    logic        m_field_end;
    logic        m_sentence_end;
    logic        m_checksum_present;
    logic        m_checksum_ok;
    logic [5:0]  m_field_count;
    logic [15:0] m_talker_code;
    logic [23:0] m_message_code;
    logic [1:0]  m_status;

    beat_t   byte_stream[$];
    result_t pending_results[$];
    int      mismatches = 0;
    logic    hold_req   = 1'b0;

    // parser model state
    phase_t      ph          = PH_IDLE;
    logic [7:0]  sum_acc     = 8'h00;
    logic [7:0]  sum_rx      = 8'h00;
    logic [5:0]  fld         = 6'd0;
    logic [2:0]  id_len      = 3'd0;
    logic [15:0] talker_acc  = 16'h0000;
    logic [23:0] message_acc = 24'h000000;
    logic        got_sum     = 1'b0;
    logic        bad_digit   = 1'b0;
    logic        overflowed  = 1'b0;

    nmea_sentence_deframer_top #(.MAX_FIELDS(MAX_FIELDS)) dut (.*);

    always #10 aclk = ~aclk;

    function automatic result_t deframe_byte(input logic [7:0] c, input logic last);
        result_t r;
        logic    term;
        int      nib;
        r = '0;
        r.char_out = c;
        term = (c == CHR_CR) || (c == CHR_LF) || (c == CHR_NUL);
        if (ph != PH_IDLE) r.field_index = fld;
        case (ph)
            PH_IDLE: begin
                if (c != CHR_DOLLAR) begin
                    r.status = term ? ST_OK : ST_OUTSIDE;
                    if (last) begin
                        r.sentence_end = 1'b1;
                        r.talker_code  = TALKER_DEFAULT;
                        r.message_code = MESSAGE_DEFAULT;
                    end
                    return r;
                end
                ph          = PH_BODY;
                sum_acc     = '0;
                sum_rx      = '0;
                fld         = '0;
                id_len      = '0;
                talker_acc  = '0;
                message_acc = '0;
                got_sum     = 1'b0;
                bad_digit   = 1'b0;
                overflowed  = 1'b0;
            end
            PH_BODY: begin
                if (c == CHR_STAR) begin
                    r.field_end = 1'b1;
                    ph = PH_HEX1;
                end else if (!term) begin
                    sum_acc ^= c;
                    if (c == CHR_COMMA) begin
                        if (int'(fld) + 1 < MAX_FIELDS) begin
                            fld++;
                            r.field_end = 1'b1;
                        end else begin
                            overflowed = 1'b1;
                            r.status = ST_OVERFLOW;
                        end
                    end else begin
                        r.is_content = 1'b1;
                        if (fld == 0 && id_len < ID_LEN) begin
                            if (id_len < TALKER_LEN) talker_acc = {talker_acc[7:0], c};
                            else message_acc = {message_acc[15:0], c};
                            id_len++;
                        end
                    end
                end
            end
            PH_HEX1, PH_HEX2: begin
                if (!term) begin
                    nib = -1;
                    if (c >= "0" && c <= "9") nib = int'(c) - 48;
                    else if (c >= "A" && c <= "F") nib = int'(c) - 55;
                    else if (c >= "a" && c <= "f") nib = int'(c) - 87;
                    if (nib < 0) begin
                        bad_digit = 1'b1;
                        r.status = ST_BAD_DIGIT;
                        ph = PH_AFTER;
                    end else if (ph == PH_HEX1) begin
                        sum_rx = {nib[3:0], 4'h0};
                        ph = PH_HEX2;
                    end else begin
                        sum_rx[3:0] = nib[3:0];
                        got_sum = 1'b1;
                        ph = PH_AFTER;
                    end
                end
            end
            default: ;
        endcase
        if (last || term) begin
            if (ph == PH_BODY) r.field_end = 1'b1;
            r.sentence_end     = 1'b1;
            r.checksum_present = got_sum;
            r.checksum_ok      = got_sum && (sum_rx == sum_acc);
            r.field_count      = fld + 6'd1;
            r.talker_code      = (id_len >= ID_LEN) ? talker_acc : TALKER_DEFAULT;
            r.message_code     = (id_len >= ID_LEN) ? message_acc : MESSAGE_DEFAULT;
            if (overflowed) r.status = ST_OVERFLOW;
            else if (bad_digit) r.status = ST_BAD_DIGIT;
            ph = PH_IDLE;
        end
        return r;
    endfunction

    // hand-written result: field 0, no content, no checksum, defaults on end
    function automatic result_t res(input logic [7:0] c, input logic fend, input logic send,
                                    input logic [5:0] cnt, input status_t st);
        result_t r;
        r = '0;
        r.char_out     = c;
        r.field_end    = fend;
        r.sentence_end = send;
        r.field_count  = cnt;
        r.talker_code  = send ? TALKER_DEFAULT : 16'h0000;
        r.message_code = send ? MESSAGE_DEFAULT : 24'h000000;
        r.status       = st;
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10) return 8'("0" + n);
        return 8'((($urandom_range(0, 1) != 0) ? "a" : "A") + n - 4'd10);
    endfunction

    task automatic push_beat(input logic [7:0] d, input logic l);
        beat_t b;
        b = '0;
        b.data = d;
        b.last = l;
        byte_stream.insert(byte_stream.size(), b);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result beat with none pending, expected none, got char %02h",
                         $time, m_char_out);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("char_out", 32'(want.char_out), 32'(m_char_out));
                check_field("field_index", 32'(want.field_index), 32'(m_field_index));
                check_field("is_content", 32'(want.is_content), 32'(m_is_content));
                check_field("field_end", 32'(want.field_end), 32'(m_field_end));
                check_field("sentence_end", 32'(want.sentence_end), 32'(m_sentence_end));
                check_field("checksum_present", 32'(want.checksum_present),
                            32'(m_checksum_present));
                check_field("checksum_ok", 32'(want.checksum_ok), 32'(m_checksum_ok));
                check_field("field_count", 32'(want.field_count), 32'(m_field_count));
                check_field("talker_code", 32'(want.talker_code), 32'(m_talker_code));
                check_field("message_code", 32'(want.message_code), 32'(m_message_code));
                check_field("status", 32'(want.status), 32'(m_status));
            end
        end
    end

    // receiver: alternating stall patterns, plus one long hold-off on request
    initial begin
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 150);
            repeat (span) begin
                @(posedge aclk);
                if (hold_req) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 1) != 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        #5ms;
        $display("nmea_sentence_deframer_top regression: fail");
        $finish;
    end

    initial begin
        beat_t      dir_tab [DIR_ROWS];
        beat_t      b;
        result_t    p;
        logic [7:0] xor_run;
        logic [7:0] ch;
        int         nfields;
        int         flen;
        int         tail;
        int         burst_left;

        dir_tab = '{
            '{8'hFF,      1'b0, 1'b1, res(8'hFF, 1'b0, 1'b0, 6'd0, ST_OUTSIDE)},
            '{CHR_NUL,    1'b0, 1'b1, res(CHR_NUL, 1'b0, 1'b0, 6'd0, ST_OK)},
            '{"A",        1'b1, 1'b1, res("A", 1'b0, 1'b1, 6'd0, ST_OUTSIDE)},
            '{CHR_DOLLAR, 1'b0, 1'b1, res(CHR_DOLLAR, 1'b0, 1'b0, 6'd0, ST_OK)},
            '{CHR_LF,     1'b0, 1'b1, res(CHR_LF, 1'b1, 1'b1, 6'd1, ST_OK)},
            '{CHR_DOLLAR, 1'b0, 1'b1, res(CHR_DOLLAR, 1'b0, 1'b0, 6'd0, ST_OK)},
            '{CHR_STAR,   1'b0, 1'b1, res(CHR_STAR, 1'b1, 1'b0, 6'd0, ST_OK)},
            '{"G",        1'b0, 1'b1, res("G", 1'b0, 1'b0, 6'd0, ST_BAD_DIGIT)},
            '{CHR_CR,     1'b0, 1'b1, res(CHR_CR, 1'b0, 1'b1, 6'd1, ST_BAD_DIGIT)},
            '{CHR_DOLLAR, 1'b0, 1'b0, result_t'('0)},
            '{"G",        1'b0, 1'b0, result_t'('0)},
            '{"P",        1'b0, 1'b0, result_t'('0)},
            '{"R",        1'b0, 1'b0, result_t'('0)},
            '{"M",        1'b0, 1'b0, result_t'('0)},
            '{"C",        1'b0, 1'b0, result_t'('0)},
            '{CHR_COMMA,  1'b0, 1'b0, result_t'('0)},
            '{CHR_DOLLAR, 1'b0, 1'b0, result_t'('0)},
            '{CHR_STAR,   1'b0, 1'b0, result_t'('0)},
            '{"a",        1'b0, 1'b0, result_t'('0)},
            '{"f",        1'b0, 1'b0, result_t'('0)},
            '{"Z",        1'b0, 1'b0, result_t'('0)},
            '{8'hFF,      1'b1, 1'b0, result_t'('0)},
            '{CHR_DOLLAR, 1'b0, 1'b0, result_t'('0)},
            '{CHR_STAR,   1'b0, 1'b0, result_t'('0)},
            '{"1",        1'b0, 1'b0, result_t'('0)},
            '{CHR_CR,     1'b0, 1'b0, result_t'('0)},
            '{CHR_DOLLAR, 1'b1, 1'b1, res(CHR_DOLLAR, 1'b1, 1'b1, 6'd1, ST_OK)}
        };
        foreach (dir_tab[k]) byte_stream.insert(byte_stream.size(), dir_tab[k]);

        while (byte_stream.size() < DIR_ROWS + RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3))
                    push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            push_beat(CHR_DOLLAR, 1'b0);
            xor_run = 8'h00;
            nfields = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 40)
                                                    : $urandom_range(1, 8);
            for (int f = 0; f < nfields; f++) begin
                if (f > 0) begin
                    push_beat(CHR_COMMA, 1'b0);
                    xor_run ^= CHR_COMMA;
                end
                if (f == 0) flen = ($urandom_range(0, 9) < 6) ? 5 : $urandom_range(0, 7);
                else flen = $urandom_range(0, 6);
                repeat (flen) begin
                    ch = ($urandom_range(0, 31) == 0) ? 8'($urandom_range(128, 255))
                                                      : 8'($urandom_range(32, 126));
                    if (ch == CHR_COMMA || ch == CHR_STAR) ch = "_";
                    push_beat(ch, 1'b0);
                    xor_run ^= ch;
                end
            end
            // 0-8 digits (8 corrupted), 9 bad digit, 10 one digit, 11 bare star,
            // 12 digits then junk, 13 no checksum
            tail = $urandom_range(0, 13);
            if (tail != 13) push_beat(CHR_STAR, 1'b0);
            if (tail == 8) xor_run ^= 8'($urandom_range(1, 255));
            if (tail <= 8 || tail == 12) begin
                push_beat(hex_char(xor_run[7:4]), 1'b0);
                push_beat(hex_char(xor_run[3:0]), 1'b0);
            end else if (tail == 9) begin
                push_beat(8'("G" + $urandom_range(0, 19)), 1'b0);
            end else if (tail == 10) begin
                push_beat(hex_char(xor_run[7:4]), 1'b0);
            end
            if (tail == 12)
                repeat ($urandom_range(1, 3)) push_beat(8'($urandom_range(32, 126)), 1'b0);
            case ($urandom_range(0, 7))
                0, 1, 2, 3: begin
                    push_beat(CHR_CR, 1'b0);
                    if ($urandom_range(0, 1) != 0) push_beat(CHR_LF, 1'b0);
                end
                4: push_beat(CHR_LF, 1'b0);
                5: push_beat(CHR_NUL, 1'b0);
                default: begin
                    b = byte_stream.pop_back();
                    b.last = 1'b1;
                    byte_stream.insert(byte_stream.size(), b);
                end
            endcase
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        burst_left = 0;
        for (int i = 0; i < byte_stream.size(); i++) begin
            if (i == DRAIN_AT) begin
                s_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
                @(posedge aclk);
            end else if (burst_left <= 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(1, 12);
            end
            if (i == HOLD_AT) begin
                hold_req   = 1'b1;
                burst_left = 400;
            end
            burst_left--;
            b = byte_stream[i];
            s_valid     <= 1'b1;
            s_data_byte <= b.data;
            s_last_byte <= b.last;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            p = deframe_byte(b.data, b.last);
            pending_results.insert(pending_results.size(), b.pinned ? b.want : p);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("nmea_sentence_deframer_top regression: pass");
        end else begin
            $display("nmea_sentence_deframer_top regression: fail");
        end
        $finish;
    end

endmodule
